@@ design/csms_pkg.sv @@
// csms_pkg: shared codes and constants of the Cunningham chain sieve solver.
// No dependencies.
`default_nettype none
package csms_pkg;
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	localparam int FIELD_W = 32;
	localparam logic [5:0] LEN_RESET = 6'd10;
	localparam logic [5:0] LEN_MAX   = 6'd32;

	typedef logic [FIELD_W-1:0] word_t;
endpackage
`default_nettype wire

@@ design/csms_if.sv @@
// csms_if: valid/ready channels of the solver (prime in, result out, config).
// Depends on csms_pkg.
`default_nettype none
interface csms_in_if;
	logic valid;
	logic ready;
	csms_pkg::word_t prime;
	csms_pkg::word_t factor_residue;
	csms_pkg::word_t half_inverse;
	modport source (output valid, output prime, output factor_residue,
		output half_inverse, input ready);
	modport sink (input valid, input prime, input factor_residue,
		input half_inverse, output ready);
endinterface

interface csms_out_if;
	logic valid;
	logic ready;
	csms_pkg::word_t multiplier;
	logic chain_kind;
	logic chain_half;
	logic [5:0] position;
	logic repeat_res;
	logic [1:0] status;
	logic last;
	modport source (output valid, output multiplier, output chain_kind,
		output chain_half, output position, output repeat_res, output status,
		output last, input ready);
	modport sink (input valid, input multiplier, input chain_kind,
		input chain_half, input position, input repeat_res, input status,
		input last, output ready);
endinterface

interface csms_cfg_if;
	logic valid;
	logic ready;
	logic [5:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/csms_divider.sv @@
// csms_divider: restoring divider, one quotient bit per cycle.
// No package dependencies.
`default_nettype none
module csms_divider #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] rem_q, quo_q, div_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [W:0] shifted, diff;
	logic take;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign take    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

@@ design/cunningham_sieve_multiplier_solver.sv @@
// cunningham_sieve_multiplier_solver: top level, sequencer around one divider.
// Depends on csms_pkg, csms_if, csms_divider.
`default_nettype none
// One prime at a time. Reductions and each extended-Euclid step use one
// restoring divider; each advance of the running inverse is a shift-add
// modular multiply; each result also scans its list in the list memory,
// reading then comparing each held entry (states S_SRD, S_SCMP). Results
// leave one at a time from an output register; the input is not ready until
// the prime's last result is transferred. Skipped and failed primes give one
// result each.
module cunningham_sieve_multiplier_solver #(
	parameter int LIST_DEPTH = 16,
	parameter int PRIME_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	csms_in_if.sink    din,
	csms_out_if.source dout,
	csms_cfg_if.sink   cfg
);
	localparam int W  = PRIME_BITS;
	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int FW = $clog2(LIST_DEPTH + 1);
	localparam int MW = $clog2(W);
	localparam int TW = W + 2;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RRES = 4'd1;
	localparam logic [3:0] S_RTWO = 4'd2;
	localparam logic [3:0] S_EUCL = 4'd3;
	localparam logic [3:0] S_EDIV = 4'd4;
	localparam logic [3:0] S_EMUL = 4'd5;
	localparam logic [3:0] S_EUPD = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;
	localparam logic [3:0] S_SSET = 4'd8;
	localparam logic [3:0] S_SRD  = 4'd9;
	localparam logic [3:0] S_SCMP = 4'd10;
	localparam logic [3:0] S_SWR  = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;
	localparam logic [3:0] S_MMUL = 4'd13;

	logic [3:0] state_q;
	logic [5:0] chain_len_q;
	logic [W-1:0] p_q, h_q, two_q, r0_q, r1_q, q_q, ri_q, acc_q, mult_q;
	logic signed [TW-1:0] t0_q, t1_q, prod_q;
	logic [MW-1:0] mb_q;
	logic [5:0] s_q, len_q;
	logic [FW-1:0] fill_q [4];
	logic [FW-1:0] idx_q, limit_q;
	logic [1:0] list_q;
	logic [W-1:0] mem [4 << IW];
	logic [W-1:0] rd_data_q;

	logic div_start, div_done;
	logic [W-1:0] div_a, div_b, div_quo, div_rem;

	csms_divider #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	logic [W-1:0] in_p, in_a;
	logic [5:0] len_eff;
	logic [6:0] len_p1;
	logic signed [TW-1:0] tf_a, tf;
	logic [W:0] dbl_a, dbl, sum_a, sum;
	logic [W-1:0] neg_ri;
	logic last_s;

	assign in_p = din.prime[W-1:0];
	assign in_a = din.factor_residue[W-1:0];

	always_comb begin
		if (chain_len_q == 6'd0)
			len_eff = 6'd1;
		else if (chain_len_q > csms_pkg::LEN_MAX)
			len_eff = csms_pkg::LEN_MAX;
		else
			len_eff = chain_len_q;
	end
	assign len_p1 = {1'b0, len_eff} + 7'd1;

	assign tf_a = (t0_q < 0) ? t0_q + TW'(p_q) : t0_q;
	assign tf   = (tf_a >= TW'(p_q)) ? tf_a - TW'(p_q) : tf_a;

	assign dbl_a = {acc_q, 1'b0};
	assign dbl   = (dbl_a >= {1'b0, p_q}) ? dbl_a - {1'b0, p_q} : dbl_a;
	assign sum_a = dbl + (two_q[mb_q] ? {1'b0, ri_q} : '0);
	assign sum   = (sum_a >= {1'b0, p_q}) ? sum_a - {1'b0, p_q} : sum_a;

	assign neg_ri = (ri_q == '0) ? '0 : p_q - ri_q;
	assign last_s = ({1'b0, s_q} + 7'd1) == {len_q, 1'b0};

	always_comb begin
		div_start = 1'b0;
		div_a     = r0_q;
		div_b     = r1_q;
		unique case (state_q)
			S_IDLE: begin
				div_start = din.valid && (in_p != '0);
				div_a     = in_a;
				div_b     = in_p;
			end
			S_RRES: begin
				div_start = div_done && (div_rem != '0);
				div_a     = h_q;
				div_b     = p_q;
			end
			S_EUCL: div_start = (r1_q != '0);
			default: ;
		endcase
	end

	assign din.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_len_q <= csms_pkg::LEN_RESET;
		end else if (cfg.valid) begin
			chain_len_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dout.valid <= 1'b0;
			ri_q       <= '0;
			for (int i = 0; i < 4; i++) fill_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						for (int i = 0; i < 4; i++) fill_q[i] <= '0;
						p_q <= in_p;
						h_q <= din.half_inverse[W-1:0];
						if (in_p == '0) begin
							ri_q              <= '0;
							dout.valid        <= 1'b1;
							dout.multiplier   <= '0;
							dout.chain_kind   <= 1'b0;
							dout.chain_half   <= 1'b0;
							dout.position     <= '0;
							dout.repeat_res   <= 1'b0;
							dout.status       <= csms_pkg::ST_FAIL;
							dout.last         <= 1'b1;
							state_q           <= S_EMIT;
						end else begin
							state_q <= S_RRES;
						end
					end
				end
				S_RRES: begin
					if (div_done) begin
						r0_q <= p_q;
						r1_q <= div_rem;
						if (div_rem == '0) begin
							ri_q            <= '0;
							dout.valid      <= 1'b1;
							dout.multiplier <= '0;
							dout.chain_kind <= 1'b0;
							dout.chain_half <= 1'b0;
							dout.position   <= '0;
							dout.repeat_res <= 1'b0;
							dout.status     <= csms_pkg::ST_SKIP;
							dout.last       <= 1'b1;
							state_q         <= S_EMIT;
						end else begin
							state_q <= S_RTWO;
						end
					end
				end
				S_RTWO: begin
					if (div_done) begin
						two_q   <= div_rem;
						t0_q    <= '0;
						t1_q    <= TW'(1);
						state_q <= S_EUCL;
					end
				end
				S_EUCL: state_q <= (r1_q != '0) ? S_EDIV : S_FIN;
				S_EDIV: begin
					if (div_done) begin
						q_q     <= div_quo;
						r0_q    <= r1_q;
						r1_q    <= div_rem;
						state_q <= S_EMUL;
					end
				end
				S_EMUL: begin
					prod_q  <= TW'($signed({1'b0, q_q}) * t1_q);
					state_q <= S_EUPD;
				end
				S_EUPD: begin
					t0_q    <= t1_q;
					t1_q    <= t0_q - prod_q;
					state_q <= S_EUCL;
				end
				S_FIN: begin
					len_q   <= len_eff;
					limit_q <= (len_p1[6:1] > 6'(LIST_DEPTH)) ? FW'(LIST_DEPTH)
						: FW'(len_p1[6:1]);
					s_q     <= '0;
					if (r0_q != W'(1) || tf == '0) begin
						ri_q            <= '0;
						dout.valid      <= 1'b1;
						dout.multiplier <= '0;
						dout.chain_kind <= 1'b0;
						dout.chain_half <= 1'b0;
						dout.position   <= '0;
						dout.repeat_res <= 1'b0;
						dout.status     <= csms_pkg::ST_FAIL;
						dout.last       <= 1'b1;
						state_q         <= S_EMIT;
					end else begin
						ri_q    <= tf[W-1:0];
						state_q <= S_SSET;
					end
				end
				S_SSET: begin
					mult_q  <= s_q[0] ? neg_ri : ri_q;
					list_q  <= {s_q[0], s_q >= len_q};
					idx_q   <= '0;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= (idx_q < fill_q[list_q]) ? S_SCMP : S_SWR;
				S_SCMP: begin
					if (rd_data_q == mult_q) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SRD;
					end
					if (rd_data_q == mult_q) begin
						dout.valid      <= 1'b1;
						dout.multiplier <= 32'(mult_q);
						dout.chain_kind <= list_q[1];
						dout.chain_half <= list_q[0];
						dout.position   <= s_q;
						dout.repeat_res <= 1'b1;
						dout.status     <= csms_pkg::ST_OK;
						dout.last       <= last_s;
					end
				end
				S_SWR: begin
					if (fill_q[list_q] < limit_q)
						fill_q[list_q] <= fill_q[list_q] + 1'b1;
					dout.valid      <= 1'b1;
					dout.multiplier <= 32'(mult_q);
					dout.chain_kind <= list_q[1];
					dout.chain_half <= list_q[0];
					dout.position   <= s_q;
					dout.repeat_res <= 1'b0;
					dout.status     <= csms_pkg::ST_OK;
					dout.last       <= last_s;
					state_q         <= S_EMIT;
				end
				S_EMIT: begin
					if (dout.ready) begin
						dout.valid <= 1'b0;
						if (dout.last) begin
							state_q <= S_IDLE;
						end else if (s_q[0]) begin
							acc_q   <= '0;
							mb_q    <= MW'(W - 1);
							state_q <= S_MMUL;
						end else begin
							s_q     <= s_q + 1'b1;
							state_q <= S_SSET;
						end
					end
				end
				S_MMUL: begin
					acc_q <= sum[W-1:0];
					mb_q  <= mb_q - 1'b1;
					if (mb_q == '0) begin
						ri_q    <= sum[W-1:0];
						s_q     <= s_q + 1'b1;
						state_q <= S_SSET;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[{list_q, idx_q[IW-1:0]}];
		if (state_q == S_SWR && fill_q[list_q] < limit_q)
			mem[{list_q, fill_q[list_q][IW-1:0]}] <= mult_q;
	end

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.status != csms_pkg::ST_OK |-> dout.last)
		else $error("failed or skipped prime without last");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(din.ready && dout.valid))
		else $error("input ready while a result is pending");

	a_mult_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.status == csms_pkg::ST_OK |-> dout.multiplier[W-1:0] < p_q)
		else $error("multiplier not reduced");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_RRES || state_q == S_RTWO || state_q == S_EDIV)
		else $error("divider finished outside a wait state");
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// testbench: self-checking bench for cunningham_sieve_multiplier_solver.
// Depends on csms_pkg, csms_if and the solver RTL. A built-in predictor of the
// multiplier sequence checks every result transfer field by field.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_DEPTH  = 16;
	localparam longint CYCLE_LIMIT = 20_000_000;

	typedef struct {
		csms_pkg::word_t mult;
		logic            kind;
		logic            half;
		logic [5:0]      pos;
		logic            rep;
		logic [1:0]      st;
		logic            last;
	} sieve_res_t;

	typedef struct {
		csms_pkg::word_t p;
		csms_pkg::word_t r;
		csms_pkg::word_t h;
		bit              typed;
		logic [1:0]      st;
	} prime_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	csms_in_if  din_if ();
	csms_out_if dout_if ();
	csms_cfg_if cfg_if ();

	cunningham_sieve_multiplier_solver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	sieve_res_t       pending_results[$];
	logic [5:0]       chain_len_reg = csms_pkg::LEN_RESET;
	csms_pkg::word_t  run_inverse = '0;
	int               errors = 0;
	int               primes_sent = 0;
	int               results_seen = 0;
	int               repeats_seen = 0;
	bit               idle_en = 1'b1;
	int               hold_req = 0;
	longint           cycles = 0;

	// residue-zero, no-inverse and reduction cases up front
	prime_row_t dir_rows[18] = '{
		'{32'd0,          32'd5,          32'd1,          1'b1, csms_pkg::ST_FAIL},
		'{32'd1,          32'd7,          32'd1,          1'b1, csms_pkg::ST_SKIP},
		'{32'd7,          32'd0,          32'd4,          1'b1, csms_pkg::ST_SKIP},
		'{32'd7,          32'd14,         32'd4,          1'b1, csms_pkg::ST_SKIP},
		'{32'd6,          32'd4,          32'd3,          1'b1, csms_pkg::ST_FAIL},
		'{32'hFFFF_FFFF,  32'd3,          32'h8000_0000,  1'b1, csms_pkg::ST_FAIL},
		'{32'd3,          32'd1,          32'd2,          1'b0, csms_pkg::ST_OK},
		'{32'd3,          32'd2,          32'd2,          1'b0, csms_pkg::ST_OK},
		'{32'd5,          32'd3,          32'd3,          1'b0, csms_pkg::ST_OK},
		'{32'd7,          32'd1,          32'd4,          1'b0, csms_pkg::ST_OK},
		'{32'hFFFF_FFFB,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, csms_pkg::ST_OK},
		'{32'hFFFF_FFFB,  32'h0000_0001,  32'h7FFF_FFFE,  1'b0, csms_pkg::ST_OK},
		'{32'hFFFF_FFFF,  32'h0000_0002,  32'h8000_0000,  1'b0, csms_pkg::ST_OK},
		'{32'd65521,      32'hDEAD_BEEF,  32'hFFFF_0000,  1'b0, csms_pkg::ST_OK},
		'{32'd8191,       32'd4096,       32'd4096,       1'b0, csms_pkg::ST_OK},
		'{32'd9,          32'd4,          32'd5,          1'b0, csms_pkg::ST_OK},
		'{32'd15,         32'd10,         32'd8,          1'b1, csms_pkg::ST_FAIL},
		'{32'h8000_0000,  32'h4000_0001,  32'h0000_0000,  1'b0, csms_pkg::ST_OK}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		din_if.valid = 1'b0;
		din_if.prime = '0;
		din_if.factor_residue = '0;
		din_if.half_inverse = '0;
		dout_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic sieve_res_t single_status(logic [1:0] st);
		sieve_res_t e;
		e = '{mult: '0, kind: 1'b0, half: 1'b0, pos: '0, rep: 1'b0, st: st,
			last: 1'b1};
		return e;
	endfunction

	// expected multiplier sequence for one prime at the current chain length
	function automatic void solve_multipliers(csms_pkg::word_t p, csms_pkg::word_t r,
		csms_pkg::word_t h);
		longint r0, r1, t0, t1, q, tmp;
		csms_pkg::word_t res, two, cur, mult;
		int len, lim, lst, i;
		csms_pkg::word_t lists[4][HOLD_DEPTH];
		int fill[4];
		bit found;
		sieve_res_t e;
		fill = '{0, 0, 0, 0};
		if (p == 0) begin
			run_inverse = '0;
			pending_results.push_back(single_status(csms_pkg::ST_FAIL));
			return;
		end
		res = r % p;
		two = h % p;
		if (res == 0) begin
			run_inverse = '0;
			pending_results.push_back(single_status(csms_pkg::ST_SKIP));
			return;
		end
		r0 = p; r1 = res; t0 = 0; t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1; r0 = r1; r1 = tmp;
			tmp = t0 - q * t1; t0 = t1; t1 = tmp;
		end
		if (t0 < 0)
			t0 = t0 + longint'(p);
		if (r0 != 1 || (t0 % longint'(p)) == 0) begin
			run_inverse = '0;
			pending_results.push_back(single_status(csms_pkg::ST_FAIL));
			return;
		end
		cur = csms_pkg::word_t'(t0 % longint'(p));
		len = chain_len_reg;
		if (len == 0)
			len = 1;
		if (len > 32)
			len = 32;
		lim = (len + 1) / 2;
		if (lim > HOLD_DEPTH)
			lim = HOLD_DEPTH;
		for (int s = 0; s < 2 * len; s++) begin
			e.kind = s[0];
			e.half = (s < len) ? 1'b0 : 1'b1;
			if (!e.kind)
				mult = cur;
			else
				mult = csms_pkg::word_t'((64'(p) - 64'(cur)) % 64'(p));
			if (e.kind)
				cur = csms_pkg::word_t'((64'(cur) * 64'(two)) % 64'(p));
			lst = e.kind * 2 + e.half;
			found = 1'b0;
			for (i = 0; i < fill[lst] && i < lim; i++)
				if (lists[lst][i] == mult)
					found = 1'b1;
			if (!found && fill[lst] < lim) begin
				lists[lst][fill[lst]] = mult;
				fill[lst]++;
			end
			e.mult = mult;
			e.pos = 6'(s);
			e.rep = found;
			e.st = csms_pkg::ST_OK;
			e.last = (s == 2 * len - 1);
			pending_results.push_back(e);
		end
		run_inverse = cur;
	endfunction

	task automatic offer_prime(csms_pkg::word_t p, csms_pkg::word_t r, csms_pkg::word_t h,
		bit typed, logic [1:0] st);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			din_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.prime <= p;
		din_if.factor_residue <= r;
		din_if.half_inverse <= h;
		do @(posedge clk); while (!din_if.ready);
		primes_sent++;
		if (typed)
			pending_results.push_back(single_status(st));
		else
			solve_multipliers(p, r, h);
	endtask

	task automatic drain_results();
		din_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_chain_len(logic [5:0] v);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		chain_len_reg = v;
	endtask

	task automatic offer_random_prime();
		csms_pkg::word_t p, r, h;
		csms_pkg::word_t small_primes[9] = '{3, 5, 7, 11, 13, 17, 31, 8191, 65521};
		int k;
		k = $urandom_range(0, 9);
		if (k <= 5) begin
			case ($urandom_range(0, 3))
				0, 1: p = small_primes[$urandom_range(0, 8)];
				2: p = $urandom | 32'd1;
				default: p = 32'hFFFF_FFFB;
			endcase
			r = $urandom_range(1, p - 1);
			h = (p >> 1) + 32'd1;
		end else if (k == 6) begin
			p = $urandom; r = $urandom; h = $urandom;
		end else if (k == 7) begin
			p = $urandom_range(3, 1000) | 32'd1;
			r = p * $urandom_range(0, 5);
			h = (p >> 1) + 32'd1;
		end else if (k == 8) begin
			p = $urandom_range(3, 70000) | 32'd1;
			r = $urandom;
			h = $urandom;
		end else begin
			p = $urandom & ~32'd1;
			r = $urandom;
			h = $urandom;
		end
		offer_prime(p, r, h, 1'b0, csms_pkg::ST_OK);
	endtask

	initial begin
		sieve_res_t e;
		forever begin
			@(posedge clk);
			if (dout_if.valid && dout_if.ready) begin
				results_seen++;
				if (dout_if.repeat_res)
					repeats_seen++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transfer mult=%h st=%0d", $time,
						dout_if.multiplier, dout_if.status);
				end else begin
					e = pending_results.pop_front();
					if (dout_if.multiplier !== e.mult || dout_if.chain_kind !== e.kind ||
						dout_if.chain_half !== e.half || dout_if.position !== e.pos ||
						dout_if.repeat_res !== e.rep || dout_if.status !== e.st ||
						dout_if.last !== e.last) begin
						errors++;
						$display({"%0t: mismatch expected mult=%h kind=%0d half=%0d",
							" pos=%0d rep=%0d st=%0d last=%0d"},
							$time, e.mult, e.kind, e.half, e.pos, e.rep, e.st, e.last);
						$display({"%0t:          actual mult=%h kind=%0d half=%0d",
							" pos=%0d rep=%0d st=%0d last=%0d"},
							$time, dout_if.multiplier, dout_if.chain_kind,
							dout_if.chain_half, dout_if.position, dout_if.repeat_res,
							dout_if.status, dout_if.last);
					end
				end
			end
			if (hold_req > 0) begin
				dout_if.ready <= 1'b0;
				hold_req--;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				dout_if.ready <= 1'b0;
				hold_req = $urandom_range(0, 3);
			end else begin
				dout_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [5:0] phase_len[6];
		phase_len = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd2};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			offer_prime(dir_rows[i].p, dir_rows[i].r, dir_rows[i].h, dir_rows[i].typed,
				dir_rows[i].st);
		foreach (phase_len[i]) begin
			write_chain_len(phase_len[i]);
			repeat (8) offer_random_prime();
		end
		for (int ph = 0; ph < 8; ph++) begin
			write_chain_len((ph % 4 == 3) ? 6'd32 : 6'($urandom_range(1, 8)));
			if (ph == 7)
				idle_en = 1'b0;
			for (int n = 0; n < 39; n++) begin
				if (ph == 2 && n == 5)
					hold_req = 400;
				if (ph == 4 && n == 20)
					drain_results();
				offer_random_prime();
			end
		end
		drain_results();
		repeat (100) @(posedge clk);
		$display("Covered %0d primes, %0d results (%0d repeats) over reset,",
			primes_sent, results_seen, repeats_seen);
		$display("extreme and random chain lengths, skipped, failed and reduced primes, stalls");
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
